// ----- sv/uv_place2d_transform_defines.svh -----
// Assertion macros shared by the uv_place2d_transform RTL.
`ifndef UV_PLACE2D_TRANSFORM_DEFINES_SVH
`define UV_PLACE2D_TRANSFORM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define UVP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define UVP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/uvp_pkg.sv -----
// Shared types, register codes and the arctangent table for the place2d transform.
package uvp_pkg;

  localparam int DATA_W           = 32;
  localparam int ANGLE_W          = 26;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANG_FRAC         = 24;
  localparam int CFG_IDX_W        = 3;
  localparam longint CORDIC_GAIN_Q30 = 64'd652032874;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_PIVOT_U  = 3'd0;
  localparam cfg_idx_t REG_PIVOT_V  = 3'd1;
  localparam cfg_idx_t REG_SCALE_U  = 3'd2;
  localparam cfg_idx_t REG_SCALE_V  = 3'd3;
  localparam cfg_idx_t REG_OFFSET_U = 3'd4;
  localparam cfg_idx_t REG_OFFSET_V = 3'd5;
  localparam cfg_idx_t REG_ROTATE   = 3'd6;
  localparam cfg_idx_t REG_MODE     = 3'd7;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_SRT = 2'd0;
  localparam mode_t MODE_TRS = 2'd1;

  typedef struct packed {
    logic signed [DATA_W-1:0] pivot_u;
    logic signed [DATA_W-1:0] pivot_v;
    logic signed [DATA_W-1:0] scale_u;
    logic signed [DATA_W-1:0] scale_v;
    logic signed [DATA_W-1:0] offset_u;
    logic signed [DATA_W-1:0] offset_v;
    mode_t                    mode;
  } place_cfg_t;

  typedef enum logic [2:0] {
    TRIG_IDLE,
    TRIG_REDUCE,
    TRIG_WRAP,
    TRIG_FOLD,
    TRIG_ROTATE,
    TRIG_ROUND
  } trig_state_t;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic [31:0] atan_deg(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd754974720;
      5'd1:  r = 32'd445687602;
      5'd2:  r = 32'd235489088;
      5'd3:  r = 32'd119537938;
      5'd4:  r = 32'd60000934;
      5'd5:  r = 32'd30029717;
      5'd6:  r = 32'd15018523;
      5'd7:  r = 32'd7509719;
      5'd8:  r = 32'd3754917;
      5'd9:  r = 32'd1877466;
      5'd10: r = 32'd938734;
      5'd11: r = 32'd469367;
      5'd12: r = 32'd234684;
      5'd13: r = 32'd117342;
      5'd14: r = 32'd58671;
      5'd15: r = 32'd29335;
      5'd16: r = 32'd14668;
      5'd17: r = 32'd7334;
      5'd18: r = 32'd3667;
      5'd19: r = 32'd1833;
      5'd20: r = 32'd917;
      5'd21: r = 32'd458;
      5'd22: r = 32'd229;
      5'd23: r = 32'd115;
      5'd24: r = 32'd57;
      5'd25: r = 32'd29;
      5'd26: r = 32'd14;
      5'd27: r = 32'd7;
      5'd28: r = 32'd4;
      5'd29: r = 32'd2;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/uv_place2d_transform.sv -----
// Top level of the place2d texture coordinate transform.
//
//  port group | dir | word contents (low bit first)        | handshake
//  in_*       | in  | u_in[31:0], v_in[63:32]              | in_tvalid / in_tready
//  out_*      | out | u_out[31:0], v_out[63:32]            | out_tvalid / out_tready
//  cfg_*      | in  | cfg_index selects register, cfg_data | cfg_valid / cfg_ready
//
// One word per cycle in and out while out_tready is high and the trig unit is not
// busy; eight register stages lie between the accepting edge and out_tvalid.
// A rotate_deg write recomputes sine and cosine in the trig unit; while it runs,
// in_tready and cfg_ready are low. The trig unit works through a sequential angle
// reduction, a wrap, a fold, the CORDIC iterations and a rounding step. rst_n is
// synchronous; it clears control state, the register file and the stored sine/cosine.
// When out_tready is low with a word waiting, all eight stages hold and in_tready
// drops in the same cycle.
`include "uv_place2d_transform_defines.svh"

module uv_place2d_transform
  import uvp_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [2*DATA_W-1:0]   in_tdata,    // u_in, v_in
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [2*DATA_W-1:0]   out_tdata,   // u_out, v_out
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [DATA_W-1:0]     cfg_data
);

  localparam int TRIG_W = FRAC_BITS + 2;
  localparam logic signed [DATA_W-1:0] ONE32 = DATA_W'(64'd1 << FRAC_BITS);

  place_cfg_t cfg_r;
  logic cfg_fire, in_fire, trig_start, trig_busy, adv;
  logic signed [TRIG_W-1:0] sin_w, cos_w;
  logic signed [DATA_W-1:0] out_u, out_v;

  assign cfg_ready  = !trig_busy;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign trig_start = cfg_fire && (cfg_index == REG_ROTATE);
  assign in_tready  = adv && !trig_busy;
  assign in_fire    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pivot_u  <= '0;
      cfg_r.pivot_v  <= '0;
      cfg_r.scale_u  <= ONE32;
      cfg_r.scale_v  <= ONE32;
      cfg_r.offset_u <= '0;
      cfg_r.offset_v <= '0;
      cfg_r.mode     <= MODE_SRT;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_PIVOT_U:  cfg_r.pivot_u  <= cfg_data;
        REG_PIVOT_V:  cfg_r.pivot_v  <= cfg_data;
        REG_SCALE_U:  cfg_r.scale_u  <= cfg_data;
        REG_SCALE_V:  cfg_r.scale_v  <= cfg_data;
        REG_OFFSET_U: cfg_r.offset_u <= cfg_data;
        REG_OFFSET_V: cfg_r.offset_v <= cfg_data;
        REG_ROTATE:   cfg_r.mode     <= cfg_r.mode;  // angle goes to the trig unit
        REG_MODE:     cfg_r.mode     <= cfg_data[1:0];
        default:      cfg_r.mode     <= cfg_r.mode;
      endcase
    end
  end

  uvp_trig #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .start (trig_start),
    .angle (signed'(cfg_data[ANGLE_W-1:0])),
    .busy  (trig_busy),
    .sin_o (sin_w),
    .cos_o (cos_w)
  );

  uvp_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_u      (signed'(in_tdata[DATA_W-1:0])),
    .in_v      (signed'(in_tdata[2*DATA_W-1:DATA_W])),
    .cfg       (cfg_r),
    .sin_i     (sin_w),
    .cos_i     (cos_w),
    .adv       (adv),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_u     (out_u),
    .out_v     (out_v)
  );

  assign out_tdata = {out_v, out_u};

  `UVP_ASSERT_NXT(a_rotate_starts_trig, trig_start, trig_busy, "rotate_deg write did not start the trig unit")

endmodule

// ----- sv/uvp_trig.sv -----
// Angle reduction and iterative CORDIC producing sine and cosine of the rotation.
`include "uv_place2d_transform_defines.svh"

module uvp_trig
  import uvp_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  localparam int TRIG_W      = FRAC_BITS + 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [ANGLE_W-1:0] angle,
  output logic                     busy,
  output logic signed [TRIG_W-1:0] sin_o,
  output logic signed [TRIG_W-1:0] cos_o
);

  localparam int AW        = 36;
  localparam int XW        = 34;
  localparam int IT_W      = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int RED_STEPS = (FRAC_BITS < 17) ? 18 - FRAC_BITS : 1;
  localparam int RED_CW    = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
  localparam int ZSH       = ANG_FRAC - FRAC_BITS;
  localparam int RND_S     = 30 - FRAC_BITS;

  localparam longint FULL_L    = 64'd360 << FRAC_BITS;
  localparam longint HALF_L    = 64'd180 << FRAC_BITS;
  localparam longint QUARTER_L = 64'd90 << FRAC_BITS;

  localparam logic        [AW-1:0] FULL_U  = AW'(FULL_L);
  localparam logic signed [AW-1:0] FULL    = AW'(FULL_L);
  localparam logic signed [AW-1:0] HALF    = AW'(HALF_L);
  localparam logic signed [AW-1:0] QUARTER = AW'(QUARTER_L);
  localparam logic signed [XW-1:0] GAIN    = XW'(CORDIC_GAIN_Q30);
  localparam logic signed [XW-1:0] RND_ADD = XW'(64'd1 << (RND_S - 1));
  localparam logic signed [XW-1:0] ONE_X   = XW'(64'd1 << FRAC_BITS);
  localparam logic signed [TRIG_W-1:0] ONE_T = TRIG_W'(64'd1 << FRAC_BITS);
  localparam logic [RED_CW-1:0] K_TOP   = RED_CW'(RED_STEPS - 1);
  localparam logic [IT_W-1:0]   I_LAST  = IT_W'(CORDIC_STEPS - 1);

  trig_state_t state_r, state_nxt;

  logic              load_en, red_en, wrap_en, fold_en, rot_en, round_en;
  logic [AW-1:0]     mag_r;
  logic              neg_r, flip_r;
  logic [RED_CW-1:0] k_r;
  logic [IT_W-1:0]   i_r;
  logic signed [AW-1:0] z_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [TRIG_W-1:0] sin_r, cos_r;

  logic signed [AW-1:0] ang_ext, a0, wrap_val, fz, at;
  logic        [AW-1:0] red_sub;
  logic                 fold_flip;
  logic signed [XW-1:0] dx, dy, cu, su;

  function automatic logic signed [TRIG_W-1:0] to_unit(input logic signed [XW-1:0] q30);
    logic signed [XW-1:0] r;
    r = (q30 + RND_ADD) >>> RND_S;
    if (r > ONE_X) r = ONE_X;
    if (r < -ONE_X) r = -ONE_X;
    return TRIG_W'(r);
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      TRIG_IDLE:   if (start) state_nxt = TRIG_REDUCE;
      TRIG_REDUCE: if (k_r == '0) state_nxt = TRIG_WRAP;
      TRIG_WRAP:   state_nxt = TRIG_FOLD;
      TRIG_FOLD:   state_nxt = TRIG_ROTATE;
      TRIG_ROTATE: if (i_r == I_LAST) state_nxt = TRIG_ROUND;
      TRIG_ROUND:  state_nxt = TRIG_IDLE;
      default:     state_nxt = TRIG_IDLE;
    endcase
  end

  // step enables
  always_comb begin
    load_en  = 1'b0;
    red_en   = 1'b0;
    wrap_en  = 1'b0;
    fold_en  = 1'b0;
    rot_en   = 1'b0;
    round_en = 1'b0;
    unique case (state_r)
      TRIG_IDLE:   load_en  = start;
      TRIG_REDUCE: red_en   = 1'b1;
      TRIG_WRAP:   wrap_en  = 1'b1;
      TRIG_FOLD:   fold_en  = 1'b1;
      TRIG_ROTATE: rot_en   = 1'b1;
      TRIG_ROUND:  round_en = 1'b1;
      default:     load_en  = 1'b0;
    endcase
  end

  assign busy = (state_r != TRIG_IDLE);

  always_comb begin
    ang_ext = AW'(angle);
    // restoring modulo: one shifted multiple of 360 degrees per cycle
    red_sub = FULL_U << k_r;
    // remainder of the magnitude, mapped into [0, 360) by the sign, then wrapped into [-180, 180)
    a0 = (neg_r && (mag_r != '0)) ? FULL - $signed(mag_r) : $signed(mag_r);
    wrap_val = (a0 >= HALF) ? a0 - FULL : a0;
    fold_flip = 1'b1;
    if (z_r > QUARTER) begin
      fz = HALF - z_r;
    end else if (z_r < -QUARTER) begin
      fz = -HALF - z_r;
    end else begin
      fz = z_r;
      fold_flip = 1'b0;
    end
    dx = y_r >>> i_r;
    dy = x_r >>> i_r;
    at = AW'(atan_deg(5'(i_r)));
    cu = x_r;
    su = y_r;
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      mag_r <= angle[ANGLE_W-1] ? -ang_ext : ang_ext;
      neg_r <= angle[ANGLE_W-1];
      k_r   <= K_TOP;
    end
    if (red_en) begin
      if (mag_r >= red_sub) mag_r <= mag_r - red_sub;
      k_r <= k_r - 1'b1;
    end
    if (wrap_en) z_r <= wrap_val;
    if (fold_en) begin
      z_r    <= fz <<< ZSH;
      flip_r <= fold_flip;
      x_r    <= GAIN;
      y_r    <= '0;
      i_r    <= '0;
    end
    if (rot_en) begin
      if (!z_r[AW-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
      i_r <= i_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TRIG_IDLE;
      sin_r   <= '0;
      cos_r   <= ONE_T;
    end else begin
      state_r <= state_nxt;
      if (round_en) begin
        sin_r <= to_unit(su);
        cos_r <= flip_r ? -to_unit(cu) : to_unit(cu);
      end
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

  `UVP_ASSERT_IMP(a_wrap_below_full, state_r == TRIG_WRAP, mag_r < FULL_U, "angle reduction left a remainder of 360 degrees or more")
  `UVP_ASSERT_NXT(a_trig_clamped, state_r == TRIG_ROUND, (sin_r <= ONE_T) && (sin_r >= -ONE_T) && (cos_r <= ONE_T) && (cos_r >= -ONE_T), "sine or cosine beyond unit range")

endmodule

// ----- sv/uvp_pipe.sv -----
// Eight-stage coordinate pipeline: pivot/offset add, scale, rotate, scale, final add.
`include "uv_place2d_transform_defines.svh"

module uvp_pipe
  import uvp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int TRIG_W   = FRAC_BITS + 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_fire,
  input  logic signed [DATA_W-1:0] in_u,
  input  logic signed [DATA_W-1:0] in_v,
  input  place_cfg_t               cfg,
  input  logic signed [TRIG_W-1:0] sin_i,
  input  logic signed [TRIG_W-1:0] cos_i,
  output logic                     adv,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_u,
  output logic signed [DATA_W-1:0] out_v
);

  localparam int NST = 8;
  localparam int PW  = DATA_W + TRIG_W;
  localparam int EW  = 66;

  localparam logic signed [DATA_W-1:0] ONE32  = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic signed [TRIG_W-1:0] ONE_T  = TRIG_W'(64'd1 << FRAC_BITS);
  localparam logic signed [EW-1:0] RND_HALF   = EW'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [EW-1:0] MAX_E      = EW'(64'sd2147483647);
  localparam logic signed [EW-1:0] MIN_E      = -EW'(64'sd2147483648);

  logic [NST-1:0] vld_r, vld_nxt;
  logic is_srt, is_trs;

  logic signed [DATA_W-1:0] in_l [2];
  logic signed [DATA_W-1:0] piv_e [2], ofs_pre [2], ofs_fin [2], scl_pre [2], scl_post [2];
  logic signed [TRIG_W-1:0] c_e, s_e;

  logic signed [DATA_W-1:0]   a_r [2], a_nxt [2];
  logic signed [2*DATA_W-1:0] p1_r [2], p1_nxt [2];
  logic signed [DATA_W-1:0]   d_r [2], d_nxt [2];
  logic signed [PW-1:0]       pxc_r, pys_r, pxs_r, pyc_r;
  logic signed [DATA_W-1:0]   r_r [2], r_nxt [2];
  logic signed [2*DATA_W-1:0] p2_r [2], p2_nxt [2];
  logic signed [DATA_W-1:0]   g_r [2], g_nxt [2];
  logic signed [DATA_W-1:0]   o_r [2], o_nxt [2];

  function automatic logic signed [DATA_W-1:0] sat_e(input logic signed [EW-1:0] x);
    logic signed [EW-1:0] t;
    t = x;
    if (t > MAX_E) t = MAX_E;
    if (t < MIN_E) t = MIN_E;
    return DATA_W'(t);
  endfunction

  function automatic logic signed [DATA_W-1:0] rnd_sat(input logic signed [EW-1:0] p);
    logic signed [EW-1:0] t;
    t = (p + RND_HALF) >>> FRAC_BITS;
    return sat_e(t);
  endfunction

  // disabled mode runs as zero pivot/offset, unit scale and identity rotation
  always_comb begin
    is_srt = 1'b0;
    is_trs = 1'b0;
    case (cfg.mode)
      MODE_SRT: is_srt = 1'b1;
      MODE_TRS: is_trs = 1'b1;
      default:  is_srt = 1'b0;
    endcase
  end

  always_comb begin
    in_l[0] = in_u;
    in_l[1] = in_v;
    piv_e[0] = (is_srt || is_trs) ? cfg.pivot_u : '0;
    piv_e[1] = (is_srt || is_trs) ? cfg.pivot_v : '0;
    ofs_pre[0] = is_trs ? cfg.offset_u : '0;
    ofs_pre[1] = is_trs ? cfg.offset_v : '0;
    ofs_fin[0] = is_srt ? cfg.offset_u : '0;
    ofs_fin[1] = is_srt ? cfg.offset_v : '0;
    scl_pre[0] = is_srt ? cfg.scale_u : ONE32;
    scl_pre[1] = is_srt ? cfg.scale_v : ONE32;
    scl_post[0] = is_trs ? cfg.scale_u : ONE32;
    scl_post[1] = is_trs ? cfg.scale_v : ONE32;
    c_e = (is_srt || is_trs) ? cos_i : ONE_T;
    s_e = (is_srt || is_trs) ? sin_i : '0;
    for (int l = 0; l < 2; l++) begin
      a_nxt[l]  = sat_e(EW'(in_l[l]) - EW'(piv_e[l]) + EW'(ofs_pre[l]));
      p1_nxt[l] = a_r[l] * scl_pre[l];
      d_nxt[l]  = rnd_sat(EW'(p1_r[l]));
      p2_nxt[l] = r_r[l] * scl_post[l];
      g_nxt[l]  = rnd_sat(EW'(p2_r[l]));
      o_nxt[l]  = sat_e(EW'(g_r[l]) + EW'(piv_e[l]) + EW'(ofs_fin[l]));
    end
    r_nxt[0] = rnd_sat(EW'(pxc_r) - EW'(pys_r));
    r_nxt[1] = rnd_sat(EW'(pxs_r) + EW'(pyc_r));
  end

  // whole pipe moves together; it holds only while the output word waits
  assign adv     = !vld_r[NST-1] || out_ready;
  assign vld_nxt = adv ? {vld_r[NST-2:0], in_fire} : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r   <= a_nxt;
      p1_r  <= p1_nxt;
      d_r   <= d_nxt;
      pxc_r <= d_r[0] * c_e;
      pys_r <= d_r[1] * s_e;
      pxs_r <= d_r[0] * s_e;
      pyc_r <= d_r[1] * c_e;
      r_r   <= r_nxt;
      p2_r  <= p2_nxt;
      g_r   <= g_nxt;
      o_r   <= o_nxt;
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_u     = o_r[0];
  assign out_v     = o_r[1];

  `UVP_ASSERT_NXT(a_stall_freezes, vld_r[NST-1] && !out_ready, vld_r == $past(vld_r), "pipeline moved while output word stalled")
  `UVP_ASSERT_NXT(a_off_passes, in_fire && !is_srt && !is_trs, (a_r[0] == $past(in_u)) && (a_r[1] == $past(in_v)), "disabled mode altered the coordinate at entry")

endmodule

// ----- verif/tb_uv_place2d_transform.sv -----
// Self-checking stream testbench for the place2d texture coordinate transform.
`timescale 1ns / 100ps

module tb_uv_place2d_transform;
  import uvp_pkg::*;

  localparam int     FRAC        = FRAC_BITS_DEF;
  localparam int     TRIG_STEPS  = CORDIC_STEPS_DEF;
  localparam longint TRIG_GAIN   = 64'sd652032874;
  localparam longint ONE_Q       = 64'sd1 <<< FRAC;
  localparam longint DEG_90      = 64'sd90 * ONE_Q;
  localparam longint DEG_180     = 64'sd180 * ONE_Q;
  localparam longint DEG_360     = 64'sd360 * ONE_Q;
  localparam int     PIPE_SLACK  = 16;
  localparam int     HOLD_CYCLES = 300;
  localparam int     CYCLE_LIMIT = 500000;

  localparam mode_t MODE_OFF   = 2'd2;
  localparam mode_t MODE_SPARE = 2'd3;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // u in the low half, matching the tdata layout
  typedef struct packed {
    logic signed [31:0] v;
    logic signed [31:0] u;
  } coord_t;

  logic           clk;
  logic           rst_n      = 1'b0;
  logic           in_tvalid  = 1'b0;
  logic           in_tready;
  logic [63:0]    in_tdata   = '0;
  logic           out_tvalid;
  logic           out_tready = 1'b0;
  logic [63:0]    out_tdata;
  logic           cfg_valid  = 1'b0;
  logic           cfg_ready;
  cfg_idx_t       cfg_index  = REG_PIVOT_U;
  logic [31:0]    cfg_data   = '0;

  uv_place2d_transform u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // shadow of the register file and of the stored sine/cosine
  place_cfg_t cfg_shadow;
  longint     trig_sin;
  longint     trig_cos;
  longint     atan_q24 [16] = '{754974720, 445687602, 235489088, 119537938, 60000934,
                                30029717, 15018523, 7509719, 3754917, 1877466,
                                938734, 469367, 234684, 117342, 58671, 29335};

  coord_t coord_q  [$];   // words waiting to be offered
  coord_t placed_q [$];   // expected placed coordinates, oldest first

  int in_acc_cnt     = 0;
  int in_sent_cnt    = 0;
  int in_gap_left    = 0;
  int in_gap_max     = 4;
  int out_acc_cnt    = 0;
  int out_seen_cnt   = 0;
  int out_stall_left = 0;
  int out_stall_max  = 4;
  int rx_hold_req    = 0;
  int rx_hold_done   = 0;
  int rx_hold_left   = 0;
  int err_cnt        = 0;
  int cycle_cnt      = 0;

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint fix_round(input longint p);
    return (p + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic longint mul_fix(input longint a, input longint b);
    return clamp32(fix_round(a * b));
  endfunction

  // Q2.30 CORDIC output down to FRAC bits, clamped to +/-1.0
  function automatic longint unit_round(input longint q30);
    longint r;
    r = (q30 + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
    if (r > ONE_Q) r = ONE_Q;
    if (r < -ONE_Q) r = -ONE_Q;
    return r;
  endfunction

  function automatic void load_trig(input logic [25:0] deg);
    longint a, x, y, z, dx, dy;
    bit     flip;
    a = longint'($signed(deg)) % DEG_360;
    flip = 1'b0;
    x = TRIG_GAIN;
    y = 0;
    if (a < 0) a += DEG_360;
    if (a >= DEG_180) a -= DEG_360;
    // fold into +/-90 so CORDIC converges; cosine picks up the sign
    if (a > DEG_90) begin
      a = DEG_180 - a;
      flip = 1'b1;
    end else if (a < -DEG_90) begin
      a = -DEG_180 - a;
      flip = 1'b1;
    end
    z = a * (64'sd1 <<< (ANG_FRAC - FRAC));
    for (int i = 0; i < TRIG_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_q24[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_q24[i];
      end
    end
    trig_cos = unit_round(x);
    trig_sin = unit_round(y);
    if (flip) trig_cos = -trig_cos;
  endfunction

  function automatic coord_t place_coord(input coord_t c);
    longint u, v, pu, pv, su, sv, ou, ov, du, dv, ru, rv;
    coord_t res;
    u  = c.u;
    v  = c.v;
    pu = cfg_shadow.pivot_u;
    pv = cfg_shadow.pivot_v;
    su = cfg_shadow.scale_u;
    sv = cfg_shadow.scale_v;
    ou = cfg_shadow.offset_u;
    ov = cfg_shadow.offset_v;
    case (cfg_shadow.mode)
      MODE_SRT: begin
        du = mul_fix(clamp32(u - pu), su);
        dv = mul_fix(clamp32(v - pv), sv);
        ru = clamp32(fix_round(du * trig_cos - dv * trig_sin));
        rv = clamp32(fix_round(du * trig_sin + dv * trig_cos));
        u  = clamp32(ru + ou + pu);
        v  = clamp32(rv + ov + pv);
      end
      MODE_TRS: begin
        du = clamp32(u - pu + ou);
        dv = clamp32(v - pv + ov);
        ru = clamp32(fix_round(du * trig_cos - dv * trig_sin));
        rv = clamp32(fix_round(du * trig_sin + dv * trig_cos));
        u  = clamp32(mul_fix(ru, su) + pu);
        v  = clamp32(mul_fix(rv, sv) + pv);
      end
      default: ;  // disabled and the spare code pass through
    endcase
    res.u = u[31:0];
    res.v = v[31:0];
    return res;
  endfunction

  // mix of extremes, full-range noise and small magnitudes
  function automatic logic [31:0] pick_q();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return Q_MAX;
      2: return Q_MIN;
      3: return 32'h0000_0000;
      4: return $urandom;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PIVOT_U:  cfg_shadow.pivot_u  = val;
      REG_PIVOT_V:  cfg_shadow.pivot_v  = val;
      REG_SCALE_U:  cfg_shadow.scale_u  = val;
      REG_SCALE_V:  cfg_shadow.scale_v  = val;
      REG_OFFSET_U: cfg_shadow.offset_u = val;
      REG_OFFSET_V: cfg_shadow.offset_v = val;
      REG_ROTATE:   load_trig(val[ANGLE_W-1:0]);
      REG_MODE:     cfg_shadow.mode     = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic put(input logic [31:0] u, input logic [31:0] v);
    coord_t c;
    c.u = u;
    c.v = v;
    coord_q.push_back(c);
  endtask

  // block is idle once every word is in and every result is out
  task automatic drain();
    while (coord_q.size() != 0 || in_acc_cnt != in_sent_cnt || placed_q.size() != 0)
      @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // input side: capture accepted words and predict their results
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_uv_place2d_transform: errors");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) begin
      in_acc_cnt++;
      placed_q.push_back(place_coord(coord_t'(in_tdata)));
    end
  end

  // sender
  always @(negedge clk) begin
    logic nxt_valid;
    nxt_valid = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_acc_cnt != in_sent_cnt) begin
        nxt_valid = 1'b1;
      end else if (in_gap_left > 0) begin
        in_gap_left--;
      end else if (coord_q.size() != 0) begin
        in_tdata    <= coord_q.pop_front();
        nxt_valid   = 1'b1;
        in_sent_cnt++;
        in_gap_left = $urandom_range(0, in_gap_max);
      end
    end
    in_tvalid <= nxt_valid;
  end

  // receiver: per-word stalls plus the occasional long hold-off
  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b0;
    if (rst_n) begin
      if (rx_hold_req != rx_hold_done) begin
        rx_hold_left = HOLD_CYCLES;
        rx_hold_done = rx_hold_req;
      end
      if (out_acc_cnt != out_seen_cnt) begin
        out_seen_cnt   = out_acc_cnt;
        out_stall_left = $urandom_range(0, out_stall_max);
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
      end else if (out_stall_left > 0) begin
        out_stall_left--;
      end else begin
        rdy = 1'b1;
      end
    end
    out_tready <= rdy;
  end

  // result checker
  always @(posedge clk) begin
    coord_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      out_acc_cnt++;
      got = coord_t'(out_tdata);
      if (placed_q.size() == 0) begin
        $error("unexpected word: u_out %0d, v_out %0d", got.u, got.v);
        err_cnt++;
      end else begin
        want = placed_q.pop_front();
        if (got.u !== want.u) begin
          $error("u_out mismatch: expected %0d, actual %0d", want.u, got.u);
          err_cnt++;
        end
        if (got.v !== want.v) begin
          $error("v_out mismatch: expected %0d, actual %0d", want.v, got.v);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    logic [31:0] rnd;
    cfg_shadow.pivot_u  = '0;
    cfg_shadow.pivot_v  = '0;
    cfg_shadow.scale_u  = 32'sd65536;
    cfg_shadow.scale_v  = 32'sd65536;
    cfg_shadow.offset_u = '0;
    cfg_shadow.offset_v = '0;
    cfg_shadow.mode     = MODE_SRT;
    trig_sin = 0;
    trig_cos = ONE_Q;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: identity placement
    put(32'h0, 32'h0);
    put(Q_MAX, Q_MIN);
    put(Q_MIN, Q_MAX);
    put(32'hFFFF_FFFF, 32'h0001_0000);
    drain();

    // pivot, scale and offset registers at extremes, zero angle taken from CORDIC
    write_reg(REG_PIVOT_U, Q_MAX);
    write_reg(REG_PIVOT_V, Q_MIN);
    write_reg(REG_SCALE_U, Q_MIN);
    write_reg(REG_SCALE_V, Q_MAX);
    write_reg(REG_OFFSET_U, Q_MIN);
    write_reg(REG_OFFSET_V, Q_MAX);
    write_reg(REG_ROTATE, 32'h0);
    write_reg(REG_MODE, {30'h0, MODE_SRT});
    put(Q_MIN, Q_MAX);
    put(Q_MAX, Q_MIN);
    put(32'h0, 32'h0);
    drain();

    // moderate values, quarter turn, TRS order
    write_reg(REG_PIVOT_U, 32'h0000_8000);
    write_reg(REG_PIVOT_V, 32'hFFFF_8000);
    write_reg(REG_SCALE_U, 32'h0002_0000);
    write_reg(REG_SCALE_V, 32'hFFFF_8000);
    write_reg(REG_OFFSET_U, 32'h0001_0000);
    write_reg(REG_OFFSET_V, 32'hFFFF_0000);
    write_reg(REG_ROTATE, 32'(DEG_90));
    write_reg(REG_MODE, {30'h0, MODE_TRS});
    put(32'h0001_0000, 32'h0002_0000);
    put(Q_MAX, Q_MIN);
    put(32'hFFFC_C000, 32'h0000_C000);
    drain();

    // angles beyond a full turn, upper data bits set on the negative one
    write_reg(REG_ROTATE, 32'h01FF_FFFF);
    write_reg(REG_MODE, {30'h0, MODE_SRT});
    put(32'h0003_0000, 32'hFFFE_0000);
    put($urandom, $urandom);
    drain();
    write_reg(REG_ROTATE, 32'hFE00_0000);
    put(32'h0003_0000, 32'hFFFE_0000);
    put($urandom, $urandom);
    drain();

    // pass-through codes; garbage in the unused data bits
    write_reg(REG_ROTATE, 32'(DEG_180));
    write_reg(REG_MODE, {30'h2AAA_AAAA, MODE_OFF});
    put(Q_MAX, 32'h1234_5678);
    put(Q_MIN, 32'hFFFF_FFFF);
    drain();
    write_reg(REG_ROTATE, 32'(-DEG_90));
    write_reg(REG_MODE, 32'hFFFF_FFFF);
    put(32'h8765_4321, Q_MAX);
    put(32'h0, Q_MIN);
    drain();

    // half-turn boundary and a full turn
    write_reg(REG_ROTATE, 32'(-DEG_180));
    write_reg(REG_MODE, {30'h0, MODE_TRS});
    put(32'h0005_0000, 32'h0000_4000);
    put(Q_MIN, Q_MIN);
    drain();
    write_reg(REG_ROTATE, 32'(DEG_360));
    put(32'hFFF0_0000, 32'h000F_FFFF);
    put(Q_MAX, Q_MAX);
    drain();

    for (int ph = 0; ph < 24; ph++) begin
      for (int r = 0; r < 8; r++) begin
        if ($urandom_range(0, 1) != 0) begin
          case (cfg_idx_t'(r)) inside
            REG_SCALE_U, REG_SCALE_V:
              rnd = ($urandom_range(0, 3) == 0) ? pick_q()
                    : $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            REG_ROTATE:
              case ($urandom_range(0, 3))
                0: rnd = $urandom;
                1: rnd = 32'((longint'($urandom_range(0, 8)) - 64'sd4) * DEG_90);
                default:
                  rnd = 32'(longint'($urandom_range(0, 32'(2 * DEG_360))) - DEG_360);
              endcase
            REG_MODE: begin
              rnd = $urandom;
              case ($urandom_range(0, 9))
                0, 1, 2, 3: rnd[1:0] = MODE_SRT;
                4, 5, 6, 7: rnd[1:0] = MODE_TRS;
                8:          rnd[1:0] = MODE_OFF;
                default:    rnd[1:0] = MODE_SPARE;
              endcase
            end
            default: rnd = pick_q();
          endcase
          write_reg(cfg_idx_t'(r), rnd);
        end
      end

      case ($urandom_range(0, 2))
        0: in_gap_max = 0;
        1: in_gap_max = 4;
        default: in_gap_max = 16;
      endcase
      case ($urandom_range(0, 2))
        0: out_stall_max = 0;
        1: out_stall_max = 4;
        default: out_stall_max = 16;
      endcase
      if (ph == 2 || ph == 4) begin
        in_gap_max    = 0;
        out_stall_max = 0;
      end

      for (int k = 0; k < 40; k++) put(pick_q(), pick_q());
      // pipeline backs up while the receiver sits on its hands
      if (ph == 4) rx_hold_req++;
      // sender waits until everything is out, mid-phase
      if (ph == 6) drain();
      for (int k = 0; k < 40; k++) put(pick_q(), pick_q());
      drain();
    end

    if (err_cnt == 0)
      $display("tb_uv_place2d_transform: clean");
    else
      $display("tb_uv_place2d_transform: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/uvp_pkg.sv
sv/uvp_trig.sv
sv/uvp_pipe.sv
sv/uv_place2d_transform.sv
verif/tb_uv_place2d_transform.sv
